@@ rtl/core/tcsw_pkg.sv @@
// Shared types, command codes and code mapping functions for the text console writer.
// Used by tcsw_out_stage and text_console_screen_writer_core; no dependencies.
`default_nettype none

package tcsw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEFAULT = 40;
  localparam int ROWS_DEFAULT    = 24;

  // Fixed field widths
  localparam int INDEX_W      = 10;
  localparam int CODE_W       = 8;
  localparam int CMD_W        = 3;
  localparam int VALUE_W      = 16;
  localparam int COL_IN_W     = 6;
  localparam int ROW_IN_W     = 5;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 24;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TEXT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RAW    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_HEX    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CURSOR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_OFFSET = 3'd4;

  // Special characters
  localparam logic [CODE_W-1:0] CHAR_NUL     = 8'd0;
  localparam logic [CODE_W-1:0] CHAR_NEWLINE = 8'd10;

  // One screen write
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [CODE_W-1:0]  data;
    logic               last;
  } cell_word_t;

  // Character to screen code; bit 7 passes through as inverse
  function automatic logic [CODE_W-1:0] text_code(input logic [CODE_W-1:0] ch);
    logic [6:0] v;
    logic [6:0] r;
    v = ch[6:0];
    if (v >= 7'd97 && v <= 7'd122) begin
      r = v;                               // lower case kept
    end else if ((v >= 7'd65 && v <= 7'd90) || (v >= 7'd32 && v <= 7'd57)) begin
      r = v - 7'd32;                       // upper case, digits, punctuation
    end else begin
      r = 7'd0;
    end
    return {ch[7], r};
  endfunction

  // Hex digit to screen code
  function automatic logic [CODE_W-1:0] hex_code(input logic [3:0] d);
    logic [CODE_W-1:0] r;
    if (d <= 4'd9) begin
      r = {4'd0, d} + 8'd16;
    end else begin
      r = {4'd0, d} + 8'd23;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/tcsw_out_stage.sv @@
// Output register for screen writes: holds one word until the sink takes it.
// Depends on tcsw_pkg (cell_word_t, widths).
`default_nettype none

module tcsw_out_stage import tcsw_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire cell_word_t             word,
  output logic                        free,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // [9:0] cell_index, [17:10] cell_data
  output logic                        m_axis_tlast   // last write of the item
);

  logic       vld;
  cell_word_t hold;

  // Slot is free when empty or draining this cycle
  assign free = !vld || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= 1'b1;
    end else if (m_axis_tready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= word;
    end
  end

  assign m_axis_tvalid = vld;
  assign m_axis_tdata  = {(OUT_TDATA_W - INDEX_W - CODE_W)'(0), hold.data, hold.index};
  assign m_axis_tlast  = hold.last;

endmodule

`default_nettype wire

@@ rtl/core/text_console_screen_writer_core.sv @@
// Text console writer: one item at a time under a small sequencer; one adder pair,
// shared by every write step, forms cell index and code. An accepted item passes
// S_DECODE; when enabled, its first write then enters the output stage from S_PUT,
// or from S_BLANK for a newline, and further writes follow one per cycle while the
// output slot is free, with S_NEWLINE before each row clear. A stalled sink then
// holds the sequencer. Sync reset clears cursor, offset, enable and the sequencer.
// Depends on tcsw_pkg and tcsw_out_stage.
`default_nettype none

module text_console_screen_writer_core import tcsw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration: enable bit
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_data,
  // command words
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] value, [21:16] column, [26:22] row
  input  wire logic [CMD_W-1:0]       s_axis_tuser,  // command
  input  wire logic                   s_axis_tlast,  // end_of_string
  // screen writes
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // [9:0] cell_index, [17:10] cell_data
  output logic                        m_axis_tlast   // last
);

  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_PUT     = 3'd2;
  localparam logic [2:0] S_NEWLINE = 3'd3;
  localparam logic [2:0] S_BLANK   = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]          state;
  logic                enable;
  logic [CMD_W-1:0]    cmd;
  logic [VALUE_W-1:0]  val;
  logic [COL_IN_W-1:0] col_in;
  logic [ROW_IN_W-1:0] row_in;
  logic                eos;
  logic [CODE_W-1:0]   code;
  logic [CODE_W-1:0]   offset;
  logic [COL_W-1:0]    cur_col;
  logic [ROW_W-1:0]    cur_row;
  logic [INDEX_W-1:0]  base;
  logic [COL_W-1:0]    bcnt;
  logic [1:0]          digit;
  logic                pend;

  logic                out_free;
  logic                go;
  logic                emitting;
  logic                more;
  logic                wrap;
  logic                blank_end;
  logic [COL_W-1:0]    sel_col;
  logic [CODE_W-1:0]   sel_code;
  logic [COL_W-1:0]    col_sat;
  logic [ROW_W-1:0]    row_sat;
  cell_word_t          word;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_valid) begin
      enable <= cfg_data;
    end
  end

  assign s_axis_tready = (state == S_IDLE);

  // Write step advances when the output slot is free, or always when disabled
  assign emitting  = (state == S_PUT) || (state == S_BLANK);
  assign go        = !enable || out_free;
  assign more      = (cmd == CMD_HEX) && (digit != 2'd3);
  assign wrap      = (cur_col == COL_LAST);
  assign blank_end = (bcnt == COL_LAST);

  // Shared adder for index and code
  assign sel_col  = (state == S_BLANK) ? bcnt : cur_col;
  assign sel_code = (state == S_BLANK) ? CODE_W'(0) : code;

  always_comb begin
    word.index = base + INDEX_W'(sel_col);
    word.data  = sel_code + offset;
    if (state == S_BLANK) begin
      word.last = blank_end && !pend;
    end else begin
      word.last = !wrap && !more;
    end
  end

  // Saturated cursor for set cursor
  assign col_sat = (8'(col_in) >= 8'(COLUMNS)) ? COL_LAST : COL_W'(col_in);
  assign row_sat = (7'(row_in) >= 7'(ROWS)) ? ROW_LAST : ROW_W'(row_in);

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      offset  <= '0;
      cur_col <= '0;
      cur_row <= '0;
      base    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (cmd)
            CMD_TEXT: begin
              if (val[7:0] == CHAR_NUL) begin
                offset <= '0;
                state  <= S_DONE;
              end else if (val[7:0] == CHAR_NEWLINE) begin
                state <= S_NEWLINE;
              end else begin
                state <= S_PUT;
              end
            end
            CMD_RAW, CMD_HEX: begin
              state <= S_PUT;
            end
            CMD_CURSOR: begin
              cur_col <= col_sat;
              cur_row <= row_sat;
              base    <= INDEX_W'(int'(row_sat) * COLUMNS);
              state   <= S_DONE;
            end
            CMD_OFFSET: begin
              offset <= val[7:0];
              state  <= S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_PUT: begin
          if (go) begin
            if (wrap) begin
              state <= S_NEWLINE;
            end else begin
              cur_col <= cur_col + COL_W'(1);
              state   <= more ? S_PUT : S_DONE;
            end
          end
        end
        S_NEWLINE: begin
          cur_col <= '0;
          if (cur_row == ROW_LAST) begin
            cur_row <= '0;
            base    <= '0;
          end else begin
            cur_row <= cur_row + ROW_W'(1);
            base    <= base + INDEX_W'(COLUMNS);
          end
          state <= S_BLANK;
        end
        S_BLANK: begin
          if (go && blank_end) begin
            state <= pend ? S_PUT : S_DONE;
          end
        end
        S_DONE: begin
          if (cmd == CMD_HEX || eos) begin
            offset <= '0;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item registers, code and counters
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      cmd    <= s_axis_tuser;
      val    <= s_axis_tdata[VALUE_W-1:0];
      col_in <= s_axis_tdata[VALUE_W +: COL_IN_W];
      row_in <= s_axis_tdata[VALUE_W + COL_IN_W +: ROW_IN_W];
      eos    <= s_axis_tlast;
    end
    if (state == S_DECODE) begin
      digit <= 2'd0;
      pend  <= 1'b0;
      if (cmd == CMD_HEX) begin
        code <= hex_code(val[15:12]);
      end else if (cmd == CMD_RAW) begin
        code <= val[7:0];
      end else begin
        code <= text_code(val[7:0]);
      end
    end
    if (state == S_PUT && go) begin
      pend <= more;
      if (more) begin
        digit <= digit + 2'd1;
        val   <= val << 4;
        code  <= hex_code(val[11:8]);
      end
    end
    if (state == S_NEWLINE) begin
      bcnt <= '0;
    end else if (state == S_BLANK && go && !blank_end) begin
      bcnt <= bcnt + COL_W'(1);
    end
  end

  tcsw_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (emitting && go && enable),
    .word          (word),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ test/text_console_screen_writer_core_tb.sv @@
// Self-checking testbench for text_console_screen_writer_core: drives command words,
// predicts every screen write with its own console state and checks each output word.
// Depends on tcsw_pkg and the core RTL only.
module text_console_screen_writer_core_tb;
  import tcsw_pkg::*;

  localparam int SCREEN_COLS  = COLUMNS_DEFAULT;
  localparam int SCREEN_ROWS  = ROWS_DEFAULT;
  localparam int SETTLE       = 100;      // covers the slowest item incl. a row clear
  localparam int STALL_CYCLES = 400;
  localparam int CYCLE_LIMIT  = 1000000;

  // commands the block leaves alone
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [VALUE_W-1:0]  value;
    logic [COL_IN_W-1:0] column;
    logic [ROW_IN_W-1:0] row;
    logic                eos;
  } console_cmd_t;

  // Console state plus the queue of screen writes still owed by the block
  class screen_scoreboard;
    cell_word_t   pending_writes[$];
    logic [5:0]   cur_col;
    logic [4:0]   cur_row;
    logic [7:0]   offset;
    bit           enabled;
    int           errors;

    function new();
      cur_col = '0;
      cur_row = '0;
      offset  = '0;
      enabled = 1'b0;
      errors  = 0;
    endfunction

    function void write_cell(logic [7:0] code, logic [5:0] col, logic [4:0] row);
      cell_word_t w;
      if (!enabled) return;
      w.index = 10'(int'(row) * SCREEN_COLS + int'(col));
      w.data  = code + offset;
      w.last  = 1'b0;
      pending_writes.push_back(w);
    endfunction

    // column 0 of the next row, then blank that row
    function void advance_row();
      cur_col = '0;
      if (cur_row == 5'(SCREEN_ROWS - 1)) cur_row = '0;
      else cur_row = cur_row + 5'd1;
      for (int i = 0; i < SCREEN_COLS; i++) write_cell(8'd0, 6'(i), cur_row);
    endfunction

    function void put_next(logic [7:0] code);
      write_cell(code, cur_col, cur_row);
      if (cur_col == 6'(SCREEN_COLS - 1)) advance_row();
      else cur_col = cur_col + 6'd1;
    endfunction

    // called for each accepted command word
    function void note_command(console_cmd_t c);
      int         first;
      logic [6:0] low7;
      logic [7:0] code;
      logic [3:0] nib;
      cell_word_t tail;
      first = pending_writes.size();
      case (c.cmd)
        CMD_TEXT: begin
          if (c.value[7:0] == CHAR_NUL) begin
            offset = '0;
          end else if (c.value[7:0] == CHAR_NEWLINE) begin
            advance_row();
          end else begin
            low7 = c.value[6:0];
            if (low7 >= 7'd65 && low7 <= 7'd90) code = {1'b0, low7} - 8'd65 + 8'd33;
            else if (low7 >= 7'd97 && low7 <= 7'd122) code = {1'b0, low7};
            else if (low7 >= 7'd48 && low7 <= 7'd57) code = {1'b0, low7} - 8'd48 + 8'd16;
            else if (low7 >= 7'd32 && low7 <= 7'd47) code = {1'b0, low7} - 8'd32;
            else code = 8'd0;
            code[7] = c.value[7];   // inverse bit
            put_next(code);
          end
        end
        CMD_RAW: begin
          put_next(c.value[7:0]);
        end
        CMD_HEX: begin
          for (int k = 3; k >= 0; k--) begin
            nib = c.value[k*4 +: 4];
            put_next(nib <= 4'd9 ? 8'(nib) + 8'd16 : 8'(nib) - 8'd10 + 8'd33);
          end
          offset = '0;
        end
        CMD_CURSOR: begin
          cur_col = (c.column >= 6'(SCREEN_COLS)) ? 6'(SCREEN_COLS - 1) : c.column;
          cur_row = (c.row >= 5'(SCREEN_ROWS)) ? 5'(SCREEN_ROWS - 1) : c.row;
        end
        CMD_OFFSET: begin
          offset = c.value[7:0];
        end
        default: ;
      endcase
      if (c.eos) offset = '0;
      if (pending_writes.size() > first) begin
        tail = pending_writes.pop_back();
        tail.last = 1'b1;
        pending_writes.push_back(tail);
      end
    endfunction

    // called for each accepted screen write word
    function void check_write(logic [9:0] index, logic [7:0] data, logic last);
      cell_word_t want;
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write: got index %0d data %02h last %0b",
                 $time, index, data, last);
        errors++;
        return;
      end
      want = pending_writes.pop_front();
      if (want.index !== index || want.data !== data || want.last !== last) begin
        $display({"%0t: write mismatch: expected index %0d data %02h last %0b,",
                  " got index %0d data %02h last %0b"},
                 $time, want.index, want.data, want.last, index, data, last);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic                   cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;  // [15:0] value, [21:16] column, [26:22] row
  logic [CMD_W-1:0]       s_axis_tuser;  // command
  logic                   s_axis_tlast;  // end_of_string
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // [9:0] cell_index, [17:10] cell_data
  logic                   m_axis_tlast;  // last

  screen_scoreboard board;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  stall_request;
  int  cycle_count;

  text_console_screen_writer_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic console_cmd_t make_cmd(logic [CMD_W-1:0] cmd, logic [15:0] value,
                                            logic [5:0] column, logic [4:0] row, logic eos);
    console_cmd_t c;
    c.cmd    = cmd;
    c.value  = value;
    c.column = column;
    c.row    = row;
    c.eos    = eos;
    return c;
  endfunction

  // Half text, with frequent newlines, the rest spread over the other commands
  function automatic console_cmd_t random_cmd();
    console_cmd_t c;
    int pick;
    int sub;
    pick     = $urandom_range(0, 99);
    sub      = $urandom_range(0, 19);
    c.value  = 16'($urandom_range(0, 65535));
    c.column = 6'($urandom_range(0, 63));
    c.row    = 5'($urandom_range(0, 31));
    c.eos    = ($urandom_range(0, 9) == 0);
    if (pick < 50) begin
      c.cmd = CMD_TEXT;
      if (sub < 3) c.value[7:0] = CHAR_NEWLINE;
      else if (sub == 3) c.value[7:0] = CHAR_NUL;
    end else if (pick < 65) begin
      c.cmd = CMD_RAW;
    end else if (pick < 75) begin
      c.cmd = CMD_HEX;
    end else if (pick < 85) begin
      c.cmd = CMD_CURSOR;
    end else if (pick < 93) begin
      c.cmd = CMD_OFFSET;
    end else begin
      c.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end
    return c;
  endfunction

  // Offer one command word; valid stays high on return so back-to-back words need
  // no drop. Anything that pauses the sender must go through wait_screen_idle.
  task automatic send_command(input console_cmd_t c);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, c.row, c.column, c.value};
    s_axis_tuser  <= c.cmd;
    s_axis_tlast  <= c.eos;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_command(c);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_command(random_cmd());
  endtask

  // Stop sending, wait for every owed write, then let the last item finish
  task automatic wait_screen_idle();
    s_axis_tvalid <= 1'b0;
    while (board.pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_enable(input logic en);
    wait_screen_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.enabled = en;
  endtask

  // Sink side: random or held-off ready, check each accepted word
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        board.check_write(m_axis_tdata[9:0], m_axis_tdata[17:10], m_axis_tlast);
      if (stall_request) begin
        hold_left = STALL_CYCLES;
        stall_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    board = new();
    send_idle_pct = 32;
    recv_idle_pct = 58;
    stall_request = 1'b0;
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_data      <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_TEXT;
    s_axis_tlast  <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // enable is 0 out of reset: cursor moves, nothing written
    send_command(make_cmd(CMD_TEXT, 16'h0041, 6'd0, 5'd0, 1'b0));
    send_command(make_cmd(CMD_TEXT, {8'h00, CHAR_NEWLINE}, 6'd0, 5'd0, 1'b0));
    set_enable(1'b1);

    // character mapping at the range edges
    send_command(make_cmd(CMD_TEXT, 16'h0041, 6'd0, 5'd0, 1'b0));   // A
    send_command(make_cmd(CMD_TEXT, 16'hFF5A, 6'd63, 5'd31, 1'b0)); // Z, upper bits set
    send_command(make_cmd(CMD_TEXT, 16'h0061, 6'd0, 5'd0, 1'b0));   // a
    send_command(make_cmd(CMD_TEXT, 16'h007A, 6'd0, 5'd0, 1'b0));   // z
    send_command(make_cmd(CMD_TEXT, 16'h0030, 6'd0, 5'd0, 1'b0));   // 0
    send_command(make_cmd(CMD_TEXT, 16'h0039, 6'd0, 5'd0, 1'b0));   // 9
    send_command(make_cmd(CMD_TEXT, 16'h0020, 6'd0, 5'd0, 1'b0));   // space
    send_command(make_cmd(CMD_TEXT, 16'h002F, 6'd0, 5'd0, 1'b0));   // slash
    send_command(make_cmd(CMD_TEXT, 16'h003A, 6'd0, 5'd0, 1'b0));   // colon maps to 0
    send_command(make_cmd(CMD_TEXT, 16'h00C1, 6'd0, 5'd0, 1'b0));   // inverse A
    send_command(make_cmd(CMD_TEXT, 16'h00FF, 6'd0, 5'd0, 1'b0));
    send_command(make_cmd(CMD_RAW, 16'h0000, 6'd0, 5'd0, 1'b0));
    send_command(make_cmd(CMD_RAW, 16'hFFFF, 6'd0, 5'd0, 1'b0));
    // offset wraps the code; a hex word clears it
    send_command(make_cmd(CMD_OFFSET, 16'h12F0, 6'd0, 5'd0, 1'b0));
    send_command(make_cmd(CMD_TEXT, 16'h0041, 6'd0, 5'd0, 1'b0));
    send_command(make_cmd(CMD_HEX, 16'hFFFF, 6'd0, 5'd0, 1'b0));
    send_command(make_cmd(CMD_HEX, 16'h0000, 6'd0, 5'd0, 1'b0));
    // saturated cursor, then a column and row wrap
    send_command(make_cmd(CMD_CURSOR, 16'h0000, 6'd63, 5'd31, 1'b0));
    send_command(make_cmd(CMD_TEXT, 16'h0078, 6'd0, 5'd0, 1'b0));
    // hex word that crosses the line end
    send_command(make_cmd(CMD_CURSOR, 16'hFFFF, 6'd38, 5'd5, 1'b0));
    send_command(make_cmd(CMD_OFFSET, 16'h0005, 6'd0, 5'd0, 1'b0));
    send_command(make_cmd(CMD_HEX, 16'hA5F0, 6'd0, 5'd0, 1'b0));
    // NUL clears the offset; newline blanks with the offset, then end of string
    send_command(make_cmd(CMD_OFFSET, 16'h0007, 6'd0, 5'd0, 1'b0));
    send_command(make_cmd(CMD_TEXT, {8'h00, CHAR_NUL}, 6'd0, 5'd0, 1'b0));
    send_command(make_cmd(CMD_TEXT, 16'h0042, 6'd0, 5'd0, 1'b0));
    send_command(make_cmd(CMD_OFFSET, 16'h0009, 6'd0, 5'd0, 1'b0));
    send_command(make_cmd(CMD_TEXT, {8'h00, CHAR_NEWLINE}, 6'd0, 5'd0, 1'b1));
    send_command(make_cmd(CMD_OFFSET, 16'h0003, 6'd0, 5'd0, 1'b0));
    send_command(make_cmd(CMD_SPARE_HI, 16'hFFFF, 6'd63, 5'd31, 1'b1));
    send_command(make_cmd(CMD_SPARE_LO, 16'h0000, 6'd0, 5'd0, 1'b0));
    send_command(make_cmd(CMD_CURSOR, 16'h0000, 6'd0, 5'd0, 1'b0));

    // sink idles more often than the sender
    run_random(90);
    set_enable(1'b0);
    run_random(25);
    set_enable(1'b1);

    // sender idles more often; one long sink hold-off and one full drain
    send_idle_pct = 58;
    recv_idle_pct = 32;
    run_random(30);
    stall_request = 1'b1;
    run_random(30);
    wait_screen_idle();
    run_random(20);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(55);

    wait_screen_idle();
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
